// ----- src/ebe_pkg.sv -----
// ----------------------------------------------------------------------------
// ebe_pkg: shared types and constants for the encoder-bin to energy unit
// Item structs, register indexes, sequencer states and the arctangent table.
// ----------------------------------------------------------------------------
package ebe_pkg;

  // Widths and fixed constants
  localparam int ANGLE_W  = 48;
  localparam int DELTA_W  = 32;
  localparam int DSP_W    = 32;
  localparam int ENERGY_W = 32;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W    = 104;   // widest shift-add product
  localparam int RAD_W    = 47;    // folded angle magnitude bits
  localparam int CNT_W    = 6;     // step counter, up to 47
  localparam int ATAN_N   = 48;
  localparam int CORDIC_STEPS_DEF = 32;

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG2RAD_Q60 = PI_Q60 / 64'd180;
  localparam logic [63:0] X0_Q60      = 64'h26DD3B6A << 30;
  localparam logic [63:0] HC_Q32      = 64'd53250807749;
  // Numerator hc * 2^49 taken down by 2^32: the starting remainder.
  localparam logic [63:0] HC_NUM_HI   = HC_Q32 << 17;

  localparam logic signed [47:0] A_MAX = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] A_MIN = 48'sh800000000000;
  localparam logic signed [48:0] DEG90  = 49'sd90 <<< 40;
  localparam logic signed [48:0] DEG180 = 49'sd180 <<< 40;

  localparam logic [31:0] D_SPACING_RST = 32'd841706216;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE   = 2'd0,
    REG_THETA0  = 2'd1,
    REG_DSPACE  = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SCALE,
    ST_ANGLE,
    ST_FOLD,
    ST_MUL_RAD,
    ST_ROT_INIT,
    ST_CORDIC,
    ST_DEN,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] encoder_delta;
    logic                      first_bin;
  } in_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]       energy_kev;
    logic signed [ANGLE_W-1:0] mid_angle_deg;
    logic                      out_of_range;
  } out_item_t;

  typedef logic [63:0] atan_tab_t [ATAN_N];

  // Shift-subtract quotient, used only on constants while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60: pi/4 for step 0, truncated Taylor sum in Q62 otherwise
  function automatic atan_tab_t atan_table();
    atan_tab_t   t;
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] term;
    int          sh;
    logic        neg;
    t[0] = PI_Q60 >> 2;
    for (int i = 1; i < ATAN_N; i++) begin
      p   = 64'd1 << (62 - i);
      sum = '0;
      k   = 64'd1;
      neg = 1'b0;
      sh  = 2 * i;
      for (int n = 0; n < 64; n++) begin
        if (p != '0) begin
          term = udiv64(p, k);
          sum  = neg ? sum - term : sum + term;
          neg  = !neg;
          k    = k + 64'd2;
          p    = (sh < 64) ? (p >> sh) : '0;
        end
      end
      t[i] = sum >> 2;
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

endpackage

// ----- src/ebe_addsub.sv -----
// ----------------------------------------------------------------------------
// ebe_addsub: shared wide adder / subtractor
// Serves the shift-add multiplications and the restoring division steps.
// ----------------------------------------------------------------------------
module ebe_addsub #(
  parameter int W = ebe_pkg::ACC_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         carry
);

  logic [W-1:0] b_eff;

  // carry out on subtract means a >= b
  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

// ----- src/encoder_bin_to_bragg_energy_unit.sv -----
// ----------------------------------------------------------------------------
// encoder_bin_to_bragg_energy_unit: encoder count per scan bin to photon energy
// Running Bragg angle, CORDIC sine and Bragg's law division, one bin at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per scan bin (encoder_delta, first_bin); valid/stall.
//   out_* : one result item per input item (energy_kev, mid_angle_deg,
//           out_of_range); valid/stall.
//   cfg_* : register writes (scale, start angle, d-spacing), index + data,
//           taken whenever valid is high (ready is always high). Write only
//           while no item is in flight.
// Sequence: 32 shift-add steps for the count scaling, 47 for the degree-to-radian
//   product, CORDIC_STEPS rotations and 32 division steps, all on one shared
//   wide adder plus the CORDIC rotator. Items whose sine is not positive skip
//   the division, items whose energy overflows skip it from the check state
//   that follows the sine test.
// Flow: one item at a time; in_stall is high from accept until the result
//   has moved into the output register.
// A stalled result waits in the output register; the next item is taken
//   meanwhile and finishes behind it.
// Reset (synchronous rst) clears the bin-start angle and restores register
//   defaults: scale 0, start angle 0, d-spacing 841706216.
// ----------------------------------------------------------------------------
module encoder_bin_to_bragg_energy_unit #(
  parameter int CORDIC_STEPS = ebe_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ebe_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ebe_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ebe_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW = ebe_pkg::ACC_W;

  ebe_pkg::state_t state, state_next;

  // Configuration and running state
  logic signed [47:0] scale;
  logic signed [47:0] theta0;
  logic [31:0]        dspace;
  logic signed [47:0] start_angle;

  // Datapath
  logic [AW-1:0]                acc;
  logic [AW-1:0]                mcand;
  logic [ebe_pkg::RAD_W-1:0]    mplier;
  logic                         neg;
  logic [ebe_pkg::CNT_W-1:0]    cnt;
  logic signed [47:0]           mid;
  logic signed [63:0]           x, y, z;
  logic [63:0]                  den;
  logic [63:0]                  rem;
  logic [31:0]                  quo;
  logic [31:0]                  energy;
  logic                         flag;

  logic in_acc, out_free, last_step;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ebe_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Shared adder operand selection
  logic [AW-1:0] au_a, au_b, au_sum;
  logic          au_sub, au_carry;
  logic [63:0]   rem_sh;

  assign rem_sh = {rem[62:0], 1'b0};

  always_comb begin
    if (state == ebe_pkg::ST_DIVIDE) begin
      au_a   = AW'(rem_sh);
      au_b   = AW'(den);
      au_sub = 1'b1;
    end else begin
      au_a   = acc;
      au_b   = mcand;
      au_sub = 1'b0;
    end
  end

  ebe_addsub #(.W(AW)) u_addsub (
    .a     (au_a),
    .b     (au_b),
    .sub   (au_sub),
    .sum   (au_sum),
    .carry (au_carry)
  );

  // Input operand magnitudes
  logic [47:0] scale_mag;
  logic [31:0] delta_mag;
  assign scale_mag = scale[47] ? 48'(-scale) : 48'(scale);
  assign delta_mag = in_data.encoder_delta[31] ? 32'(-in_data.encoder_delta)
                                               : 32'(in_data.encoder_delta);

  // Saturated scaled delta and the two angle sums
  logic signed [47:0] scaled;
  logic signed [48:0] mid_sum, start_sum;
  logic signed [47:0] mid_sat, start_sat;

  always_comb begin
    if (neg) begin
      scaled = (acc > AW'(64'h800000000000)) ? ebe_pkg::A_MIN : 48'(-acc[47:0]);
    end else begin
      scaled = (acc > AW'(64'h7FFFFFFFFFFF)) ? ebe_pkg::A_MAX : acc[47:0];
    end
    mid_sum   = {start_angle[47], start_angle} + {{2{scaled[47]}}, scaled[47:1]};
    start_sum = {start_angle[47], start_angle} + {scaled[47], scaled};
    if (mid_sum[48] != mid_sum[47]) begin
      mid_sat = mid_sum[48] ? ebe_pkg::A_MIN : ebe_pkg::A_MAX;
    end else begin
      mid_sat = mid_sum[47:0];
    end
    if (start_sum[48] != start_sum[47]) begin
      start_sat = start_sum[48] ? ebe_pkg::A_MIN : ebe_pkg::A_MAX;
    end else begin
      start_sat = start_sum[47:0];
    end
  end

  // Fold into [-90, 90] degrees
  logic signed [48:0] mid_ext, folded, folded_mag;
  always_comb begin
    mid_ext = {mid[47], mid};
    if (mid_ext > ebe_pkg::DEG90) begin
      folded = ebe_pkg::DEG180 - mid_ext;
    end else if (mid_ext < -ebe_pkg::DEG90) begin
      folded = -ebe_pkg::DEG180 - mid_ext;
    end else begin
      folded = mid_ext;
    end
    folded_mag = folded[48] ? -folded : folded;
  end

  // CORDIC rotation step
  logic signed [63:0] xs, ys, atan_v;
  logic [63:0]        rad;
  assign xs     = x >>> cnt;
  assign ys     = y >>> cnt;
  assign atan_v = ebe_pkg::ATAN_TAB[cnt];
  assign rad    = acc[103:40];

  // Step counter end of phase
  always_comb begin
    unique case (state)
      ebe_pkg::ST_MUL_SCALE: last_step = (cnt == ebe_pkg::CNT_W'(ebe_pkg::DELTA_W - 1));
      ebe_pkg::ST_MUL_RAD:   last_step = (cnt == ebe_pkg::CNT_W'(ebe_pkg::RAD_W - 1));
      ebe_pkg::ST_CORDIC:    last_step = (cnt == ebe_pkg::CNT_W'(CORDIC_STEPS - 1));
      ebe_pkg::ST_DIVIDE:    last_step = (cnt == ebe_pkg::CNT_W'(ebe_pkg::ENERGY_W - 1));
      default:               last_step = 1'b0;
    endcase
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ebe_pkg::ST_IDLE:      if (in_valid) state_next = ebe_pkg::ST_MUL_SCALE;
      ebe_pkg::ST_MUL_SCALE: if (last_step) state_next = ebe_pkg::ST_ANGLE;
      ebe_pkg::ST_ANGLE:     state_next = ebe_pkg::ST_FOLD;
      ebe_pkg::ST_FOLD:      state_next = ebe_pkg::ST_MUL_RAD;
      ebe_pkg::ST_MUL_RAD:   if (last_step) state_next = ebe_pkg::ST_ROT_INIT;
      ebe_pkg::ST_ROT_INIT:  state_next = ebe_pkg::ST_CORDIC;
      ebe_pkg::ST_CORDIC:    if (last_step) state_next = ebe_pkg::ST_DEN;
      ebe_pkg::ST_DEN:       state_next = (y > 64'sd0) ? ebe_pkg::ST_CHECK : ebe_pkg::ST_DONE;
      ebe_pkg::ST_CHECK:     state_next = (ebe_pkg::HC_NUM_HI >= den) ? ebe_pkg::ST_DONE
                                                                      : ebe_pkg::ST_DIVIDE;
      ebe_pkg::ST_DIVIDE:    if (last_step) state_next = ebe_pkg::ST_DONE;
      ebe_pkg::ST_DONE:      if (out_free) state_next = ebe_pkg::ST_IDLE;
      default:               state_next = ebe_pkg::ST_IDLE;
    endcase
  end

  // Configuration registers and bin-start angle
  always_ff @(posedge clk) begin
    if (rst) begin
      scale       <= '0;
      theta0      <= '0;
      dspace      <= ebe_pkg::D_SPACING_RST;
      start_angle <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ebe_pkg::REG_SCALE:  scale  <= cfg_data;
          ebe_pkg::REG_THETA0: theta0 <= cfg_data;
          ebe_pkg::REG_DSPACE: dspace <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_acc && in_data.first_bin) begin
        start_angle <= theta0;
      end else if (state == ebe_pkg::ST_ANGLE) begin
        start_angle <= start_sat;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ebe_pkg::ST_IDLE: begin
        acc    <= '0;
        mcand  <= AW'(scale_mag);
        mplier <= ebe_pkg::RAD_W'(delta_mag);
        neg    <= scale[47] ^ in_data.encoder_delta[31];
        cnt    <= '0;
      end
      ebe_pkg::ST_MUL_SCALE, ebe_pkg::ST_MUL_RAD: begin
        if (mplier[0]) acc <= au_sum;
        mcand  <= {mcand[AW-2:0], 1'b0};
        mplier <= mplier >> 1;
        cnt    <= last_step ? '0 : cnt + 1'b1;
      end
      ebe_pkg::ST_ANGLE: begin
        mid <= mid_sat;
      end
      ebe_pkg::ST_FOLD: begin
        acc    <= '0;
        mcand  <= AW'(ebe_pkg::DEG2RAD_Q60);
        mplier <= folded_mag[ebe_pkg::RAD_W-1:0];
        neg    <= folded[48];
        cnt    <= '0;
      end
      ebe_pkg::ST_ROT_INIT: begin
        x   <= ebe_pkg::X0_Q60;
        y   <= '0;
        z   <= neg ? -$signed(rad) : $signed(rad);
        cnt <= '0;
      end
      ebe_pkg::ST_CORDIC: begin
        if (!z[63]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_v;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_v;
        end
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
      ebe_pkg::ST_DEN: begin
        den    <= 64'({32'd0, dspace} * {30'd0, y[63:30]});
        energy <= '1;
        flag   <= 1'b1;
      end
      ebe_pkg::ST_CHECK: begin
        rem <= ebe_pkg::HC_NUM_HI;
        quo <= '0;
        cnt <= '0;
      end
      ebe_pkg::ST_DIVIDE: begin
        rem <= au_carry ? au_sum[63:0] : rem_sh;
        quo <= {quo[30:0], au_carry};
        cnt <= last_step ? '0 : cnt + 1'b1;
        if (last_step) begin
          energy <= {quo[30:0], au_carry};
          flag   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ebe_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ebe_pkg::ST_DONE && out_free) begin
      out_data.energy_kev    <= energy;
      out_data.mid_angle_deg <= mid;
      out_data.out_of_range  <= flag;
    end
  end

  // Checks on the sequencer and datapath
  a_cordic_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ebe_pkg::ST_CORDIC |-> cnt < ebe_pkg::CNT_W'(CORDIC_STEPS))
    else $error("CORDIC step count past the configured steps");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ebe_pkg::ST_DIVIDE |-> rem < den)
    else $error("division remainder not below divisor");

  a_scale_mplier: assert property (@(posedge clk) disable iff (rst)
    state == ebe_pkg::ST_MUL_SCALE |-> mplier[ebe_pkg::RAD_W-1:ebe_pkg::DELTA_W] == '0)
    else $error("count multiplier wider than the encoder delta");

endmodule

// ----- bench/encoder_bin_to_bragg_energy_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_bin_to_bragg_energy_unit_tb: self-checking bench for the energy unit
// Drives scan bins and register writes and predicts the mid angle, energy and
// out-of-range flag of every bin. Each result is checked in order against the
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module encoder_bin_to_bragg_energy_unit_tb;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [47:0] DEG1 = 48'd1 << 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ebe_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ebe_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ebe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ebe_pkg::CFG_W-1:0]     cfg_data = '0;

  always #10 clk = ~clk;

  encoder_bin_to_bragg_energy_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Predictor state: registers, running angle and arctangent table
  logic signed [47:0] scale_q = '0;
  logic signed [47:0] theta0_q = '0;
  logic [31:0]        dspace_q = ebe_pkg::D_SPACING_RST;
  logic signed [47:0] bin_angle = '0;
  logic signed [63:0] atan_q60 [ebe_pkg::ATAN_N];

  ebe_pkg::out_item_t expected_q[$];
  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_flagged = 0;
  int  n_writes = 0;
  int  idle_cnt = 0;
  int  hold_cycles = 0;
  bit  calm = 1'b0;

  // atan(2^-i): pi/4 at step 0, else a truncated Q62 series scaled to Q60
  function automatic void build_atan_table();
    logic [63:0] p, sum, k;
    int sh;
    bit neg;
    atan_q60[0] = ebe_pkg::PI_Q60 >> 2;
    for (int i = 1; i < ebe_pkg::ATAN_N; i++) begin
      p = 64'd1 << (62 - i);
      sum = '0;
      k = 64'd1;
      neg = 1'b0;
      sh = 2 * i;
      while (p != 0) begin
        sum = neg ? sum - p / k : sum + p / k;
        neg = !neg;
        k += 64'd2;
        p = (sh < 64) ? (p >> sh) : '0;
      end
      atan_q60[i] = sum >> 2;
    end
  endfunction

  // CORDIC sine of an angle in degrees, Q60 result
  function automatic logic signed [63:0] sine_of_deg(logic signed [47:0] ang);
    logic signed [48:0] a;
    logic [47:0]        mag;
    logic [111:0]       prod;
    logic signed [63:0] x, y, z, xs, ys;
    a = ang;
    if (a > ebe_pkg::DEG90) a = ebe_pkg::DEG180 - a;
    else if (a < -ebe_pkg::DEG90) a = -ebe_pkg::DEG180 - a;
    mag = (a < 0) ? 48'(-a) : 48'(a);
    prod = mag * ebe_pkg::DEG2RAD_Q60;
    z = prod[103:40];
    if (a < 0) z = -z;
    x = ebe_pkg::X0_Q60;
    y = '0;
    for (int i = 0; i < ebe_pkg::CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q60[i];
      end else begin
        x += ys; y -= xs; z += atan_q60[i];
      end
    end
    return y;
  endfunction

  // Expected result of one bin; advances the running angle
  function automatic ebe_pkg::out_item_t predict_bin(ebe_pkg::in_item_t it);
    ebe_pkg::out_item_t r;
    logic signed [79:0] prod;
    logic signed [49:0] acc;
    logic signed [47:0] scaled, mid;
    logic signed [63:0] s;
    logic [63:0]        den;
    logic [127:0]       num, quo;
    if (it.first_bin) bin_angle = theta0_q;
    prod = scale_q * it.encoder_delta;
    scaled = (prod > ebe_pkg::A_MAX) ? ebe_pkg::A_MAX :
             (prod < ebe_pkg::A_MIN) ? ebe_pkg::A_MIN : 48'(prod);
    acc = bin_angle + (scaled >>> 1);
    mid = (acc > ebe_pkg::A_MAX) ? ebe_pkg::A_MAX :
          (acc < ebe_pkg::A_MIN) ? ebe_pkg::A_MIN : 48'(acc);
    acc = bin_angle + scaled;
    bin_angle = (acc > ebe_pkg::A_MAX) ? ebe_pkg::A_MAX :
                (acc < ebe_pkg::A_MIN) ? ebe_pkg::A_MIN : 48'(acc);
    r.mid_angle_deg = mid;
    r.energy_kev = '1;
    r.out_of_range = 1'b1;
    s = sine_of_deg(mid);
    if (s > 0) begin
      den = 64'(dspace_q * (64'(s) >> 30));
      num = 128'(ebe_pkg::HC_Q32) << 49;
      if (den != 0) begin
        quo = num / den;
        if (quo[127:32] == '0) begin
          r.energy_kev = quo[31:0];
          r.out_of_range = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Sender idle gap before the next item
  task automatic idle_gap(int max_gap);
    int g;
    g = calm ? 0 : $urandom_range(max_gap);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Offer one bin and hold it until accepted
  task automatic send_bin(logic signed [31:0] delta, logic first);
    ebe_pkg::in_item_t it;
    idle_gap(12);
    it.encoder_delta = delta;
    it.first_bin = first;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_bin(it));
    n_items++;
    @(negedge clk);
  endtask

  // Wait until every expected result is back, plus the block's latency
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // One register write; the caller drops cfg_valid after the last one
  task automatic write_reg(ebe_pkg::cfg_reg_t idx, logic [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ebe_pkg::REG_SCALE:  scale_q = val;
      ebe_pkg::REG_THETA0: theta0_q = val;
      ebe_pkg::REG_DSPACE: dspace_q = val[31:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [47:0] sc, logic [47:0] th, logic [31:0] d);
    drain();
    write_reg(ebe_pkg::REG_SCALE, sc);
    write_reg(ebe_pkg::REG_THETA0, th);
    write_reg(ebe_pkg::REG_DSPACE, 48'(d));
    cfg_valid <= 1'b0;
  endtask

  // Directed bins: field extremes, folding, saturation, flag cases
  task automatic test_directed();
    calm = 1'b1;
    send_bin(32'sd1000, 1'b0);               // reset registers: scale 0
    set_regs(DEG1, 48'd20 << 40, ebe_pkg::D_SPACING_RST);
    send_bin(32'sd0, 1'b1);
    send_bin(32'sd10, 1'b0);
    send_bin(32'sd150, 1'b0);                // past 90 degrees, folded
    send_bin(-32'sd400, 1'b0);               // mid angle -20 degrees, no folding
    send_bin(-32'sd200, 1'b1);               // negative angle, flagged
    send_bin(32'sh7FFFFFFF, 1'b1);           // scaled delta saturates
    send_bin(32'sh7FFFFFFF, 1'b0);           // start angle saturates
    send_bin(32'sh80000000, 1'b1);
    send_bin(32'sh80000000, 1'b0);
    set_regs(48'd1, 48'd0, ebe_pkg::D_SPACING_RST);
    send_bin(32'sd0, 1'b1);                  // zero sine
    send_bin(32'sd1, 1'b0);                  // scaled delta halves to zero: zero sine again
    set_regs(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'd0);
    send_bin(32'sd0, 1'b1);                  // zero d-spacing
    send_bin(-32'sd1, 1'b0);
    set_regs(48'h8000_0000_0000, 48'h8000_0000_0000, 32'hFFFF_FFFF);
    send_bin(32'sd0, 1'b1);
    send_bin(-32'sd1, 1'b0);
    send_bin(32'sd1, 1'b0);
    set_regs(48'd109951163, 48'd45 << 40, 32'hFFFF_FFFF);
    send_bin(32'sd5000, 1'b1);
    send_bin(-32'sd5000, 1'b0);
    calm = 1'b0;
  endtask

  // Scans: first bin then plausible deltas, with some full-range noise
  task automatic run_scans(int n_bins);
    int left;
    int run;
    logic signed [31:0] d;
    left = n_bins;
    while (left > 0) begin
      run = $urandom_range(60, 5);
      calm = ($urandom_range(5) == 0);
      for (int i = 0; i < run && left > 0; i++, left--) begin
        if ($urandom_range(9) == 0) d = $urandom;
        else d = $signed($urandom_range(40000)) - 32'sd20000;
        send_bin(d, (i == 0) || ($urandom_range(30) == 0));
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random_settings();
    logic [47:0] sc, th;
    logic [31:0] d;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: begin sc = 48'd109951163; th = 48'($urandom_range(85, 3)) << 40;
                 d = ebe_pkg::D_SPACING_RST; end
        1: begin sc = -48'sd54975581; th = 48'($urandom_range(60, 10)) << 40;
                 d = $urandom_range(32'h7000_0000, 32'h1000_0000); end
        2: begin sc = 48'({$urandom, $urandom}) & 48'h0000_0FFF_FFFF;
                 th = 48'({$urandom, $urandom}); d = $urandom; end
        3: begin sc = 48'({$urandom, $urandom}); th = 48'({$urandom, $urandom});
                 d = $urandom; end
        default: begin sc = 48'd1099511627; th = 48'd170 << 40;
                       d = 32'hFFFF_FFFF; end
      endcase
      set_regs(sc, th, d);
      run_scans(150);
    end
  endtask

  // Receiver holds off while bins keep coming, then a sender pause
  task automatic test_backpressure();
    set_regs(48'd109951163, 48'd30 << 40, ebe_pkg::D_SPACING_RST);
    hold_cycles = 800;
    for (int i = 0; i < 8; i++) send_bin($signed($urandom_range(2000)), i == 0);
    drain();
    run_scans(30);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    run_scans(30);
  endtask

  // Receiver: random stall per result, plus the long hold when requested
  initial begin
    int wait_n;
    wait_n = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (wait_n > 0) begin
        wait_n--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall && !calm) wait_n = $urandom_range(12);
    end
  end

  // Result checker
  always @(posedge clk) begin
    ebe_pkg::out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no bin outstanding: %p", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.out_of_range) n_flagged++;
        if (out_data.energy_kev !== e.energy_kev) begin
          $error("energy_kev exp %h got %h", e.energy_kev, out_data.energy_kev);
          errors++;
        end
        if (out_data.mid_angle_deg !== e.mid_angle_deg) begin
          $error("mid_angle_deg exp %h got %h", e.mid_angle_deg,
                 out_data.mid_angle_deg);
          errors++;
        end
        if (out_data.out_of_range !== e.out_of_range) begin
          $error("out_of_range exp %b got %b", e.out_of_range,
                 out_data.out_of_range);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    build_atan_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    drain();
    $display("%0d bins, %0d results (%0d flagged), %0d register writes;",
             n_items, n_results, n_flagged, n_writes);
    $display("covered folding, saturation, zero divisor and output hold-off.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- encoder_bin_to_bragg_energy_unit.f -----
src/ebe_pkg.sv
src/ebe_addsub.sv
src/encoder_bin_to_bragg_energy_unit.sv
bench/encoder_bin_to_bragg_energy_unit_tb.sv
